// File: src/asf_pkg.sv
// Package for the adjacent-sample features unit: widths, the per-packet
// snapshot that crosses from front end to back end, and sequencer codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package asf_pkg;

  localparam int MAX_SAMPLES = 512;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

  // iteration counts of the shared arithmetic unit
  localparam int MUL_ITERS  = 40;
  localparam int DIV_ITERS  = 64;
  localparam int SQRT_ITERS = 40;
  localparam int ITER_W     = 7;

  // running sums of one packet, handed to the back end at the last sample
  typedef struct packed {
    logic [CNT_W-1:0]   count;
    logic signed [7:0]  first;
    logic signed [7:0]  lastv;
    logic [17:0]        sad;
    logic [26:0]        ssq;
    logic signed [17:0] sall;
    logic [24:0]        ssqall;
    logic signed [24:0] spp;
    logic               ovf;
  } asf_snap_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_START,
    ST_RUN,
    ST_STORE,
    ST_OUT
  } asf_state_t;

  typedef enum logic [3:0] {
    OP_NN,
    OP_A,
    OP_B,
    OP_NXY,
    OP_SXSY,
    OP_NX2,
    OP_SXX,
    OP_NY2,
    OP_SYY,
    OP_DMAD,
    OP_DVAR,
    OP_T12,
    OP_SQRT,
    OP_DCOR
  } asf_op_t;

  typedef enum logic [1:0] {
    UK_MUL,
    UK_DIV,
    UK_SQRT
  } asf_kind_t;

endpackage
`default_nettype wire

// File: src/adjacent_sample_features_unit.sv
// Adjacent-sample features: one sample per cycle in while the queue is not full,
// one result per packet. The result is computed after the last sample by the
// bit-serial multiply/divide/sqrt unit; a packet under two samples skips it.
// The back end works on one packet at a time, so up to two finished packets
// queue up and input stalls when the queue is full.
// Reset: synchronous rst clears sums, queue, sequencer and result valid.
`timescale 1ns / 1ps
`default_nettype none
module adjacent_sample_features_unit (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,  // [7:0] sample
  input  wire         s_tlast,
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [55:0] m_tdata,  // [15:0] mean_abs_diff, [37:16] diff_variance,
                                // [53:38] correlation, [55:54] zero
  output logic [1:0]  m_tuser   // [0] too_short, [1] overlong
);
  import asf_pkg::*;

  logic               push, q_full, pop, q_valid;
  asf_snap_t          push_data, pop_data;
  logic [15:0]        mad;
  logic [21:0]        var_o;
  logic signed [15:0] corr;
  logic               shortf, ovf;

  asf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_sample (s_tdata),
    .in_last   (s_tlast),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  asf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .pop_data  (pop_data)
  );

  asf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_mad   (mad),
    .out_var   (var_o),
    .out_corr  (corr),
    .out_short (shortf),
    .out_ovf   (ovf)
  );

  assign m_tdata = {2'b00, corr, var_o, mad};
  assign m_tuser = {ovf, shortf};

`ifndef SYNTHESIS
  // a short packet carries all-zero features
  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[53:0] == 54'd0)
    else $error("short packet with non-zero features");

  // a zero mean difference goes with a zero difference variance
  a_mad_var: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[15:0] == 16'd0 |-> m_tdata[37:16] == 22'd0)
    else $error("variance non-zero with zero mean difference");

  // the back end only pops a queue that holds a packet
  a_pop: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

// File: src/asf_front.sv
// Front end: accepts samples and keeps the running per-packet sums.
// Pushes a snapshot into the queue at the last sample. Depends on asf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module asf_front (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire [7:0]        in_sample,
  input  wire              in_last,
  output logic             push,
  output asf_pkg::asf_snap_t push_data,
  input  wire              q_full
);
  import asf_pkg::*;

  logic [CNT_W-1:0]   count;
  logic signed [7:0]  first;
  logic signed [7:0]  prev;
  logic [17:0]        sad;
  logic [26:0]        ssq;
  logic signed [17:0] sall;
  logic [24:0]        ssqall;
  logic signed [24:0] spp;
  logic               ovf;

  logic               acc;
  logic signed [7:0]  s;
  logic signed [8:0]  d;
  logic [7:0]         ad;
  logic signed [15:0] pp;
  asf_snap_t          nx;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign s        = in_sample;
  assign d        = 9'(s) - 9'(prev);
  assign ad       = d[8] ? 8'(-d) : d[7:0];
  assign pp       = 16'(prev) * 16'(s);

  // next sums for this sample
  always_comb begin
    nx.count  = count;
    nx.first  = first;
    nx.lastv  = prev;
    nx.sad    = sad;
    nx.ssq    = ssq;
    nx.sall   = sall;
    nx.ssqall = ssqall;
    nx.spp    = spp;
    nx.ovf    = ovf;
    if (count < CNT_W'(MAX_SAMPLES)) begin
      if (count == '0) begin
        nx.first = s;
      end else begin
        nx.sad = sad + 18'(ad);
        nx.ssq = ssq + 27'(16'(ad) * 16'(ad));
        nx.spp = spp + 25'(pp);
      end
      nx.sall   = sall + 18'(s);
      nx.ssqall = ssqall + 25'(16'(16'(s) * 16'(s)));
      nx.lastv  = s;
      nx.count  = count + 1'b1;
    end else begin
      nx.ovf = 1'b1;
    end
  end

  assign push      = acc && in_last;
  assign push_data = nx;

  // sum registers, cleared after each packet
  always_ff @(posedge clk) begin
    if (rst || push) begin
      count  <= '0;
      first  <= '0;
      prev   <= '0;
      sad    <= '0;
      ssq    <= '0;
      sall   <= '0;
      ssqall <= '0;
      spp    <= '0;
      ovf    <= 1'b0;
    end else if (acc) begin
      count  <= nx.count;
      first  <= nx.first;
      prev   <= nx.lastv;
      sad    <= nx.sad;
      ssq    <= nx.ssq;
      sall   <= nx.sall;
      ssqall <= nx.ssqall;
      spp    <= nx.spp;
      ovf    <= nx.ovf;
    end
  end

endmodule
`default_nettype wire

// File: src/asf_queue.sv
// Two-entry queue of packet snapshots between front and back end.
// Depends on asf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module asf_queue (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  input  asf_pkg::asf_snap_t push_data,
  output logic               full,
  input  wire                pop,
  output logic               not_empty,
  output asf_pkg::asf_snap_t pop_data
);
  import asf_pkg::*;

  asf_snap_t  mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;

  assign full      = fill == 2'd2;
  assign not_empty = fill != 2'd0;
  assign pop_data  = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// File: src/asf_back.sv
// Back end: sequencer over one shared bit-serial multiply / divide / square
// root unit that turns a packet snapshot into the result item.
// Depends on asf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module asf_back (
  input  wire                clk,
  input  wire                rst,
  input  wire                q_valid,
  input  asf_pkg::asf_snap_t q_data,
  output logic               pop,
  output logic               out_valid,
  input  wire                out_ready,
  output logic [15:0]        out_mad,
  output logic [21:0]        out_var,
  output logic signed [15:0] out_corr,
  output logic               out_short,
  output logic               out_ovf
);
  import asf_pkg::*;

  asf_state_t state, state_next;
  asf_op_t    op;

  // packet terms
  logic [CNT_W-1:0]   n;
  logic [17:0]        sad;
  logic [26:0]        ssq;
  logic signed [24:0] spp;
  logic signed [18:0] sx, sy;
  logic signed [25:0] sx2, sy2;
  logic               shortf, ovf;
  logic [19:0]        nn;
  logic [37:0]        a_r, b_r;
  logic signed [39:0] pn, pxy, tx1, sxx, ty1, syy;
  logic [79:0]        prod;
  logic [39:0]        den;
  logic [15:0]        mad;
  logic [21:0]        var_r;
  logic signed [15:0] corr;

  // arithmetic unit registers
  asf_kind_t         kind;
  logic [ITER_W-1:0] cnt;
  logic [79:0]       mcd, macc;
  logic [39:0]       mpl;
  logic              mneg;
  logic [63:0]       dvd, quo;
  logic [39:0]       dvs, rem;
  logic [79:0]       rad;
  logic [39:0]       rt;
  logic [41:0]       srem;

  // derived terms
  logic signed [40:0] num, t1, t2;
  logic [39:0]        t1c, t2c, nmag;
  logic [37:0]        amb;
  logic signed [39:0] ma, mb;
  logic [39:0]        uma, umb;
  logic [63:0]        op_dvd;
  logic [39:0]        op_dvs;
  logic [79:0]        res;
  logic [40:0]        rem_sh;
  logic [43:0]        srem_sh, trial;
  logic [15:0]        lsq, fsq;

  assign num  = 41'(pn) - 41'(pxy);
  assign t1   = 41'(tx1) - 41'(sxx);
  assign t2   = 41'(ty1) - 41'(syy);
  assign t1c  = t1[40] ? '0 : t1[39:0];
  assign t2c  = t2[40] ? '0 : t2[39:0];
  assign nmag = num[40] ? 40'(-num) : num[39:0];
  assign amb  = (a_r > b_r) ? a_r - b_r : '0;
  assign lsq  = 16'(16'(q_data.lastv) * 16'(q_data.lastv));
  assign fsq  = 16'(16'(q_data.first) * 16'(q_data.first));

  // operand selection for the current step
  always_comb begin
    ma     = '0;
    mb     = '0;
    op_dvd = '0;
    op_dvs = 40'd1;
    case (op)
      OP_NN:   begin ma = 40'(n);   mb = 40'(n);   end
      OP_A:    begin ma = 40'(n);   mb = 40'(ssq); end
      OP_B:    begin ma = 40'(sad); mb = 40'(sad); end
      OP_NXY:  begin ma = 40'(n);   mb = 40'(spp); end
      OP_SXSY: begin ma = 40'(sx);  mb = 40'(sy);  end
      OP_NX2:  begin ma = 40'(n);   mb = 40'(sx2); end
      OP_SXX:  begin ma = 40'(sx);  mb = 40'(sx);  end
      OP_NY2:  begin ma = 40'(n);   mb = 40'(sy2); end
      OP_SYY:  begin ma = 40'(sy);  mb = 40'(sy);  end
      OP_T12:  begin ma = t1c;      mb = t2c;      end
      OP_DMAD: begin op_dvd = {38'd0, sad, 8'd0}; op_dvs = 40'(n); end
      OP_DVAR: begin op_dvd = {18'd0, amb, 8'd0}; op_dvs = 40'(nn); end
      OP_DCOR: begin op_dvd = {9'd0, nmag, 15'd0}; op_dvs = den; end
      default: begin end
    endcase
  end

  assign uma = ma[39] ? 40'(-ma) : ma;
  assign umb = mb[39] ? 40'(-mb) : mb;

  // one divide step and one square root step
  assign rem_sh  = {rem, dvd[63]};
  assign srem_sh = {srem, rad[79:78]};
  assign trial   = {2'b00, rt, 2'b01};

  // unit result
  always_comb begin
    case (kind)
      UK_MUL:  res = mneg ? 80'(-macc) : macc;
      UK_DIV:  res = 80'(quo);
      UK_SQRT: res = 80'(rt);
      default: res = '0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        pop        = 1'b1;
        state_next = (q_data.count < CNT_W'(2)) ? ST_OUT : ST_START;
      end
      ST_START: state_next = ST_RUN;
      ST_RUN:   if (cnt == '0) state_next = ST_STORE;
      ST_STORE: begin
        if (op == OP_DCOR || (op == OP_SQRT && res == '0)) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_START;
        end
      end
      ST_OUT:   if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // step counter of the sequencer
  always_ff @(posedge clk) begin
    if (rst || state == ST_LOAD) begin
      op <= OP_NN;
    end else if (state == ST_STORE) begin
      op <= asf_op_t'(op + 1'b1);
    end
  end

  // take in the queue head as it is popped
  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      n      <= q_data.count - 1'b1;
      sad    <= q_data.sad;
      ssq    <= q_data.ssq;
      spp    <= q_data.spp;
      sx     <= 19'(q_data.sall) - 19'(q_data.lastv);
      sy     <= 19'(q_data.sall) - 19'(q_data.first);
      sx2    <= 26'(q_data.ssqall) - 26'(lsq);
      sy2    <= 26'(q_data.ssqall) - 26'(fsq);
      shortf <= q_data.count < CNT_W'(2);
      ovf    <= q_data.ovf;
      mad    <= '0;
      var_r  <= '0;
      corr   <= '0;
    end else if (state == ST_STORE) begin
      case (op)
        OP_NN:   nn   <= res[19:0];
        OP_A:    a_r  <= res[37:0];
        OP_B:    b_r  <= res[37:0];
        OP_NXY:  pn   <= res[39:0];
        OP_SXSY: pxy  <= res[39:0];
        OP_NX2:  tx1  <= res[39:0];
        OP_SXX:  sxx  <= res[39:0];
        OP_NY2:  ty1  <= res[39:0];
        OP_SYY:  syy  <= res[39:0];
        OP_T12:  prod <= res;
        OP_SQRT: den  <= res[39:0];
        OP_DMAD: mad  <= (res > 80'hFFFF) ? 16'hFFFF : res[15:0];
        OP_DVAR: var_r <= (res > 80'h3FFFFF) ? 22'h3FFFFF : res[21:0];
        OP_DCOR: begin
          if (num[40]) begin
            corr <= (res > 80'd32768) ? 16'sh8000 : 16'(-res[15:0]);
          end else begin
            corr <= (res > 80'd32767) ? 16'sh7FFF : res[15:0];
          end
        end
        default: begin end
      endcase
    end
  end

  // shared bit-serial unit
  always_ff @(posedge clk) begin
    if (state == ST_START) begin
      case (op)
        OP_DMAD, OP_DVAR, OP_DCOR: begin
          kind <= UK_DIV;
          cnt  <= ITER_W'(DIV_ITERS - 1);
        end
        OP_SQRT: begin
          kind <= UK_SQRT;
          cnt  <= ITER_W'(SQRT_ITERS - 1);
        end
        default: begin
          kind <= UK_MUL;
          cnt  <= ITER_W'(MUL_ITERS - 1);
        end
      endcase
      mcd  <= 80'(uma);
      mpl  <= umb;
      macc <= '0;
      mneg <= ma[39] ^ mb[39];
      dvd  <= op_dvd;
      dvs  <= op_dvs;
      quo  <= '0;
      rem  <= '0;
      rad  <= prod;
      rt   <= '0;
      srem <= '0;
    end else if (state == ST_RUN) begin
      cnt <= cnt - 1'b1;
      case (kind)
        UK_MUL: begin
          if (mpl[0]) macc <= macc + mcd;
          mcd <= {mcd[78:0], 1'b0};
          mpl <= {1'b0, mpl[39:1]};
        end
        UK_DIV: begin
          dvd <= {dvd[62:0], 1'b0};
          if (rem_sh >= {1'b0, dvs}) begin
            rem <= 40'(rem_sh - {1'b0, dvs});
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= rem_sh[39:0];
            quo <= {quo[62:0], 1'b0};
          end
        end
        UK_SQRT: begin
          rad <= {rad[77:0], 2'b00};
          if (srem_sh >= trial) begin
            srem <= 42'(srem_sh - trial);
            rt   <= {rt[38:0], 1'b1};
          end else begin
            srem <= srem_sh[41:0];
            rt   <= {rt[38:0], 1'b0};
          end
        end
        default: begin end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!out_valid || out_ready)) begin
      out_mad   <= mad;
      out_var   <= var_r;
      out_corr  <= corr;
      out_short <= shortf;
      out_ovf   <= ovf;
    end
  end

endmodule
`default_nettype wire

// File: dv/testbench.sv
// Self-checking bench for adjacent_sample_features_unit: drives sample packets,
// predicts each packet result in a scoreboard class and checks every output item.
// Depends on asf_pkg and the unit under src/.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import asf_pkg::*;

  typedef struct packed {
    logic [15:0] mad;
    logic [21:0] dvar;
    logic [15:0] corr;
    logic        shrt;
    logic        ovl;
  } packet_result_t;

  // Packet-feature predictor and store of expected results
  class packet_features_sb;
    packet_result_t expected_q[$];
    int unsigned    n_errors;
    longint         prev_s, first_s, sad, ssq, sall, ssqall, spp;
    int unsigned    count;
    bit             ovf;

    function void clear_sums();
      prev_s = 0; first_s = 0; sad = 0; ssq = 0; sall = 0; ssqall = 0; spp = 0;
      count = 0; ovf = 0;
    endfunction

    function logic [63:0] floor_sqrt(logic [127:0] v);
      logic [63:0]  r;
      logic [63:0]  c;
      logic [127:0] cc;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
        c  = r | (64'd1 << i);
        cc = {64'd0, c} * {64'd0, c};
        if (cc <= v) r = c;
      end
      return r;
    endfunction

    // note one accepted sample; a packet end queues its expected result
    function void note_sample(logic [7:0] raw, bit lst);
      longint         s, d, n, sx, sy, sx2, sy2, num, t1, t2, mag;
      longint unsigned a, b, mad, dv, q;
      logic [63:0]    den;
      packet_result_t r;
      s = longint'($signed(raw));
      if (count < MAX_SAMPLES) begin
        if (count == 0) first_s = s;
        else begin
          d    = s - prev_s;
          if (d < 0) d = -d;
          sad += d;
          ssq += d * d;
          spp += prev_s * s;
        end
        sall   += s;
        ssqall += s * s;
        prev_s  = s;
        count++;
      end else ovf = 1;
      if (!lst) return;
      r = '0;
      r.ovl = ovf;
      if (count < 2) r.shrt = 1;
      else begin
        n   = count - 1;
        sx  = sall - prev_s;
        sy  = sall - first_s;
        sx2 = ssqall - prev_s * prev_s;
        sy2 = ssqall - first_s * first_s;
        num = n * spp - sx * sy;
        t1  = n * sx2 - sx * sx;
        t2  = n * sy2 - sy * sy;
        if (t1 < 0) t1 = 0;
        if (t2 < 0) t2 = 0;
        a   = n * ssq;
        b   = sad * sad;
        mad = (sad * 256) / n;
        if (mad > 65535) mad = 65535;
        dv  = (a > b) ? ((a - b) * 256) / (n * n) : 0;
        if (dv > 22'h3FFFFF) dv = 22'h3FFFFF;
        r.mad  = mad[15:0];
        r.dvar = dv[21:0];
        den = floor_sqrt({64'd0, t1} * {64'd0, t2});
        if (den != 0) begin
          mag = (num < 0) ? -num : num;
          q   = (mag * 32768) / den;
          if (num < 0) begin
            if (q > 32768) q = 32768;
            r.corr = 16'(-q);
          end else begin
            if (q > 32767) q = 32767;
            r.corr = q[15:0];
          end
        end
      end
      expected_q.push_back(r);
      clear_sums();
    endfunction

    function void check_result(logic [55:0] data, logic [1:0] user);
      packet_result_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result item: tdata=%h tuser=%b", data, user);
        n_errors++;
        return;
      end
      e = expected_q.pop_front();
      if (data[15:0] !== e.mad) begin
        $error("mean_abs_diff: expected %0d, got %0d", e.mad, data[15:0]); n_errors++;
      end
      if (data[37:16] !== e.dvar) begin
        $error("diff_variance: expected %0d, got %0d", e.dvar, data[37:16]); n_errors++;
      end
      if (data[53:38] !== e.corr) begin
        $error("correlation: expected %0d, got %0d", $signed(e.corr),
               $signed(data[53:38]));
        n_errors++;
      end
      if (data[55:54] !== 2'b00) begin
        $error("tdata pad: expected 0, got %b", data[55:54]); n_errors++;
      end
      if (user[0] !== e.shrt) begin
        $error("too_short: expected %0d, got %0d", e.shrt, user[0]); n_errors++;
      end
      if (user[1] !== e.ovl) begin
        $error("overlong: expected %0d, got %0d", e.ovl, user[1]); n_errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [55:0] m_tdata;
  logic [1:0]  m_tuser;

  packet_features_sb sb = new();
  bit          calm = 0;        // no idling on either side while set
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned cycles = 0;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  adjacent_sample_features_unit i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial forever #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: random back-pressure, handshake sampled mid-cycle
  initial begin
    bit          hs;
    logic [55:0] d;
    logic [1:0]  u;
    forever begin
      @(negedge clk);
      hs = m_tvalid && m_tready && !rst;
      d  = m_tdata;
      u  = m_tuser;
      @(posedge clk);
      if (hs) begin
        sb.check_result(d, u);
        results_seen++;
      end
      m_tready <= calm || ($urandom_range(0, 99) >= 13);
    end
  end

  // one sample item, with an optional random gap before it
  task automatic send_sample(logic [7:0] s, bit lst);
    bit ok;
    if (!calm && $urandom_range(0, 99) < 13) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= s;
    s_tlast  <= lst;
    do begin
      @(negedge clk);
      ok = s_tready;
      @(posedge clk);
    end while (!ok);
    sb.note_sample(s, lst);
    items_sent++;
  endtask

  task automatic send_packet(int len, bit narrow);
    logic [7:0] base;
    base = $urandom;
    for (int i = 0; i < len; i++)
      send_sample(narrow ? 8'(base + $urandom_range(0, 6) - 3) : 8'($urandom), i == len - 1);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    sb.clear_sums();
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: short packets, extremes, alternation, constant run
    send_sample(8'h7F, 1);
    send_sample(8'h80, 1);
    send_sample(8'h80, 0); send_sample(8'h7F, 1);
    send_sample(8'h80, 0); send_sample(8'h7F, 0); send_sample(8'h80, 0);
    send_sample(8'h7F, 1);
    send_sample(8'h05, 0); send_sample(8'h05, 0); send_sample(8'h05, 1);
    send_sample(8'h00, 0); send_sample(8'h01, 0); send_sample(8'h02, 0);
    send_sample(8'h03, 1);
    send_sample(8'hFF, 0); send_sample(8'h55, 0); send_sample(8'hAA, 1);
    drain();    // sender holds off until every result is back

    // full-length packet, an overlong one (last on an ignored sample), then a six-sample one
    calm = 1;
    send_packet(MAX_SAMPLES, 0);
    calm = 0;
    send_packet(MAX_SAMPLES + 3, 0);
    for (int i = 0; i < 5; i++) send_sample(8'($urandom), 0);
    send_sample(8'($urandom), 1);

    // random packets, mostly short; some narrow-range for strong correlation
    while (items_sent < 1400) begin
      calm = (items_sent > 1100 && items_sent < 1200);
      if ($urandom_range(0, 9) == 0) send_packet($urandom_range(1, 2), 0);
      else send_packet($urandom_range(3, 24), $urandom_range(0, 2) == 0);
    end

    drain();
    repeat (1000) @(posedge clk);
    if (sb.n_errors == 0 && sb.expected_q.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire
